// File: rtl/core/matrix_inverse_gauss_jordan_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gauss-Jordan inverter
// Shared property forms used by the top module.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_GAUSS_JORDAN_TOP_MACROS_SVH
`define MATRIX_INVERSE_GAUSS_JORDAN_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define MIGJ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MIGJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/migj_pkg.sv
// ----------------------------------------------------------------------------
// migj_pkg
// Types, constants and helpers for the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package migj_pkg;
    localparam int MAX_SIZE      = 4;
    localparam int FRACTION_BITS = 16;
    localparam int STORE_DEPTH   = 2 * MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int IDX_W         = $clog2(MAX_SIZE) + 1;
    localparam int CNT_W         = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int COL_W         = $clog2(2 * MAX_SIZE) + 1;
    localparam int DIV_W         = 32 + FRACTION_BITS + 1;
    localparam int DIVC_W        = $clog2(DIV_W + 1);
    localparam int PROD_W        = 64 - FRACTION_BITS;

    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRACTION_BITS);

    typedef enum logic [0:0] {
        REG_MATRIX_SIZE = 1'b0
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_IDENT,
        ST_PIV_RD,
        ST_PIV_WAIT,
        ST_PIV_DIV,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_ROW_DIV,
        ST_EL_RD,
        ST_EL_WAIT,
        ST_EL_MUL,
        ST_EL_WR,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_W-1:0]  num;
        logic signed [32:0]       den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [DIV_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [31:0] sat32(input logic signed [DIV_W+16:0] v,
                                          output logic sat);
        sat = 1'b0;
        if (v > $signed({{(DIV_W-15){1'b0}}, 32'h7fffffff})) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end else if (v < -$signed({{(DIV_W-15){1'b0}}, 32'h80000000})) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction
endpackage

// File: rtl/core/migj_ram.sv
// ----------------------------------------------------------------------------
// migj_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module migj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/core/migj_div.sv
// ----------------------------------------------------------------------------
// migj_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module migj_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  migj_pkg::t_div_req  i_req,
    output migj_pkg::t_div_rsp  o_rsp
);
    import migj_pkg::*;

    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [32:0]       r_rem, n_rem;
    logic [32:0]       r_den, n_den;
    logic              r_neg, n_neg;
    logic [DIVC_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [33:0]       w_trial;
    logic [DIV_W-1:0]  w_anum;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_anum = i_req.num[DIV_W-1] ? DIV_W'(-i_req.num) : DIV_W'(i_req.num);
        w_trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = w_anum;
            n_rem  = '0;
            n_den  = i_req.den[32] ? 33'(-i_req.den) : 33'(i_req.den);
            n_neg  = i_req.num[DIV_W-1] ^ i_req.den[32];
            n_cnt  = DIVC_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                n_rem = w_trial[32:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIVC_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// File: rtl/core/matrix_inverse_gauss_jordan_top.sv
// After the last element the identity half is filled, then each column is normalised
//   and eliminated on the bit-serial divider (a zero pivot skips its column), then each result is read out.
// Throughput: one matrix at a time; loading accepts one element per cycle.
// The bit-serial divider sets the pace of elimination.
// Reset: synchronous active low; size 4, load count and flags cleared.
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan_top
// Gauss-Jordan matrix inverter, signed Q16.16, no pivoting, APB size register.
// ----------------------------------------------------------------------------
`include "matrix_inverse_gauss_jordan_top_macros.svh"
module matrix_inverse_gauss_jordan_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_matrix_element,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_inverse_element,
    output logic        o_last_element,
    output logic        o_singular,
    output logic        o_saturated
);
    import migj_pkg::*;

    t_state r_state, n_state;
    logic [2:0]       r_size;
    logic [IDX_W-1:0] w_n;
    logic [CNT_W-1:0] r_load, n_load;
    logic             r_sing, n_sing, r_satf, n_satf;
    logic [IDX_W-1:0] r_col, n_col, r_row, n_row;
    logic [COL_W-1:0] r_c, n_c;
    logic [31:0]      r_piv, n_piv, r_fac, n_fac;
    logic [31:0]      r_pivrow [2*MAX_SIZE];
    logic             w_pr_we;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic             r_last, n_last;
    logic [31:0]      r_oel, n_oel;
    logic             r_oval, n_oval;
    logic             w_cfg_wr;

    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic [31:0]       w_wdata, w_rdata;
    t_div_req          w_dreq;
    t_div_rsp          w_drsp;

    logic signed [63:0]      w_mul;
    logic signed [63:0]      w_rnd;
    logic signed [DIV_W+16:0] w_ext;
    logic [31:0]             w_sat_v;
    logic                    w_sat;

    assign w_n = (r_size == 3'd0) ? IDX_W'(1) :
                 (IDX_W'(r_size) > IDX_W'(MAX_SIZE)) ? IDX_W'(MAX_SIZE) : IDX_W'(r_size);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input logic [IDX_W-1:0] n);
        return ADDR_W'(r * (2 * n) + c);
    endfunction

    migj_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    migj_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign pready   = 1'b1;
    assign prdata   = {29'd0, r_size};
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign w_mul    = $signed(r_fac) * $signed(r_pivrow[r_c[COL_W-2:0]]);
    // bias negative products so the shift truncates toward zero
    assign w_rnd    = w_mul + (w_mul[63] ? $signed(64'((64'd1 << FRACTION_BITS) - 1))
                                         : 64'sd0);

    always_comb begin
        n_state = r_state;
        n_load  = r_load;
        n_sing  = r_sing;
        n_satf  = r_satf;
        n_col   = r_col;
        n_row   = r_row;
        n_c     = r_c;
        n_piv   = r_piv;
        n_fac   = r_fac;
        n_prod  = r_prod;
        n_last  = r_last;
        n_oel   = r_oel;
        n_oval  = r_oval;
        w_we    = 1'b0;
        w_addr  = '0;
        w_wdata = '0;
        w_pr_we = 1'b0;
        w_dreq  = '0;
        w_ext   = '0;
        w_sat_v = '0;
        w_sat   = 1'b0;
        o_ready = 1'b0;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            ST_LOAD: begin
                o_ready = 1'b1;
                w_addr  = addr_of(r_row, r_c, w_n);
                if (i_valid) begin
                    w_we    = 1'b1;
                    w_wdata = i_matrix_element;
                    n_load  = r_load + 1'b1;
                    if (IDX_W'(r_c) == w_n - 1'b1) begin
                        n_c   = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                    if (n_load == CNT_W'(w_n * w_n)) begin
                        n_state = ST_IDENT;
                        n_row   = '0;
                        n_c     = '0;
                    end
                end
            end
            ST_IDENT: begin
                w_we    = 1'b1;
                w_addr  = addr_of(r_row, COL_W'(w_n) + r_c, w_n);
                w_wdata = (IDX_W'(r_c) == r_row) ? ONE_Q : 32'd0;
                if (IDX_W'(r_c) == w_n - 1'b1) begin
                    n_c = '0;
                    if (r_row == w_n - 1'b1) begin
                        n_state = ST_PIV_RD;
                        n_col   = '0;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            ST_PIV_RD: begin
                w_addr  = addr_of(r_col, COL_W'(r_col), w_n);
                n_state = ST_PIV_WAIT;
            end
            ST_PIV_WAIT: begin
                n_piv = w_rdata;
                n_c   = '0;
                if (w_rdata == 32'd0) begin
                    n_sing = 1'b1;
                    if (r_col == w_n - 1'b1) begin
                        n_state = ST_OUT_RD;
                        n_row   = '0;
                        n_c     = '0;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = ST_PIV_RD;
                    end
                end else begin
                    n_state = ST_ROW_RD;
                end
            end
            ST_ROW_RD: begin
                w_addr  = addr_of(r_col, r_c, w_n);
                n_state = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                w_pr_we       = 1'b1;
                w_dreq.start  = 1'b1;
                w_dreq.num    = DIV_W'($signed(w_rdata)) <<< FRACTION_BITS;
                w_dreq.den    = 33'($signed(r_piv));
                n_state       = ST_ROW_DIV;
            end
            ST_ROW_DIV: begin
                w_addr = addr_of(r_col, r_c, w_n);
                if (w_drsp.done) begin
                    w_ext   = (DIV_W+17)'(w_drsp.quo);
                    w_sat_v = sat32(w_ext, w_sat);
                    w_we    = 1'b1;
                    w_wdata = w_sat_v;
                    n_satf  = r_satf | w_sat;
                    if (r_c == COL_W'(2 * w_n) - 1'b1) begin
                        n_c     = '0;
                        n_row   = (r_col == '0) ? IDX_W'(1) : '0;
                        n_state = (w_n == IDX_W'(1)) ? ST_EL_WR : ST_PIV_DIV;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = ST_ROW_RD;
                    end
                end
            end
            ST_PIV_DIV: begin
                // read row entry in pivot column for factor
                w_addr  = addr_of(r_row, COL_W'(r_col), w_n);
                n_state = ST_EL_RD;
            end
            ST_EL_RD: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = DIV_W'($signed(w_rdata)) <<< FRACTION_BITS;
                w_dreq.den   = 33'($signed(r_piv));
                n_state      = ST_EL_WAIT;
            end
            ST_EL_WAIT: begin
                if (w_drsp.done) begin
                    w_ext   = (DIV_W+17)'(w_drsp.quo);
                    n_fac   = sat32(w_ext, w_sat);
                    n_satf  = r_satf | w_sat;
                    n_c     = '0;
                    n_state = ST_EL_MUL;
                end
            end
            ST_EL_MUL: begin
                w_addr  = addr_of(r_row, r_c, w_n);
                n_prod  = PROD_W'(w_rnd >>> FRACTION_BITS);
                n_state = ST_EL_WR;
            end
            ST_EL_WR: begin
                if (r_row == r_col || r_row == w_n) begin
                    // next row or next column
                    if (r_row + 1'b1 == r_col ? (r_col + 1'b1 >= w_n) : (r_row + 1'b1 >= w_n)) begin
                        if (r_col == w_n - 1'b1) begin
                            n_state = ST_OUT_RD;
                            n_row   = '0;
                        end else begin
                            n_col   = r_col + 1'b1;
                            n_state = ST_PIV_RD;
                        end
                        n_c = '0;
                    end else begin
                        n_row   = (r_row + 1'b1 == r_col) ? r_row + 2'd2 : r_row + 1'b1;
                        n_state = ST_PIV_DIV;
                    end
                end else begin
                    w_addr  = addr_of(r_row, r_c, w_n);
                    w_ext   = (DIV_W+17)'($signed(w_rdata)) - (DIV_W+17)'($signed(r_prod));
                    w_sat_v = sat32(w_ext, w_sat);
                    w_we    = 1'b1;
                    w_wdata = w_sat_v;
                    n_satf  = r_satf | w_sat;
                    if (r_c == COL_W'(2 * w_n) - 1'b1) begin
                        n_c = '0;
                        if (r_row + 1'b1 == r_col ? (r_col + 1'b1 >= w_n)
                                                  : (r_row + 1'b1 >= w_n)) begin
                            if (r_col == w_n - 1'b1) begin
                                n_state = ST_OUT_RD;
                                n_row   = '0;
                            end else begin
                                n_col   = r_col + 1'b1;
                                n_state = ST_PIV_RD;
                            end
                        end else begin
                            n_row   = (r_row + 1'b1 == r_col) ? r_row + 2'd2 : r_row + 1'b1;
                            n_state = ST_PIV_DIV;
                        end
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = ST_EL_MUL;
                    end
                end
            end
            ST_OUT_RD: begin
                w_addr  = addr_of(r_row, COL_W'(w_n) + r_c, w_n);
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (!r_oval || i_ready) begin
                    n_oel  = w_rdata;
                    n_oval = 1'b1;
                    n_last = (r_row == w_n - 1'b1) && (IDX_W'(r_c) == w_n - 1'b1);
                    n_state = ST_OUT_HOLD;
                end else begin
                    w_addr = addr_of(r_row, COL_W'(w_n) + r_c, w_n);
                end
            end
            ST_OUT_HOLD: begin
                if (r_last) begin
                    if (!r_oval || i_ready) begin
                        n_state = ST_LOAD;
                        n_load  = '0;
                        n_sing  = 1'b0;
                        n_satf  = 1'b0;
                        n_last  = 1'b0;
                        n_row   = '0;
                        n_c     = '0;
                    end
                end else begin
                    if (IDX_W'(r_c) == w_n - 1'b1) begin
                        n_c   = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                    n_state = ST_OUT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
        if (w_cfg_wr) begin
            n_load = '0;
            n_sing = 1'b0;
            n_satf = 1'b0;
            n_row  = '0;
            n_c    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_size  <= 3'd4;
            r_load  <= '0;
            r_sing  <= 1'b0;
            r_satf  <= 1'b0;
            r_oval  <= 1'b0;
            r_last  <= 1'b0;
            r_row   <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_size <= pwdata[2:0];
            end
            r_load <= n_load;
            r_sing <= n_sing;
            r_satf <= n_satf;
            r_oval <= n_oval;
            r_last <= n_last;
            r_row  <= n_row;
            r_c    <= n_c;
        end
        r_col  <= n_col;
        r_piv  <= n_piv;
        r_fac  <= n_fac;
        r_prod <= n_prod;
        r_oel  <= n_oel;
        if (w_pr_we) begin
            r_pivrow[r_c[COL_W-2:0]] <= w_rdata;
        end
    end

    assign o_valid           = r_oval;
    assign o_inverse_element = r_oel;
    assign o_last_element    = r_oval && r_last && (r_state == ST_OUT_HOLD);
    assign o_singular        = r_sing;
    assign o_saturated       = r_satf;

    `MIGJ_ASSERT_IMPL(a_ready_only_load, i_clk, i_rst_n, o_ready, r_state == ST_LOAD, "ready outside load")
    `MIGJ_ASSERT_IMPL(a_no_out_in_load, i_clk, i_rst_n, r_state == ST_LOAD && !r_oval, !o_last_element, "last without beat")
    `MIGJ_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, i_valid && o_ready && !w_cfg_wr && r_load != CNT_W'(w_n*w_n-1), r_load == $past(r_load) + 1'b1, "load count slip")
endmodule

// File: bench/matrix_inverse_gauss_jordan_checker.sv
// ----------------------------------------------------------------------------
// Gauss-Jordan inverter checker
// Watches the element and inverse channels and the size register writes,
// predicts each inverse in Q16.16 and compares every output beat.
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [31:0] i_matrix_element,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] o_inverse_element,
    input  logic               o_last_element,
    input  logic               o_singular,
    input  logic               o_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);
    import migj_pkg::*;

    typedef struct packed {
        logic [31:0] elem;
        logic        last;
        logic        sing;
        logic        sat;
    } t_inv_beat;

    t_inv_beat   inverse_q[$];
    longint      aug[STORE_DEPTH];
    logic [2:0]  size_reg;
    int          loaded;
    bit          sing_flag;
    bit          sat_flag;

    assign o_pending = inverse_q.size();

    function automatic longint clip(longint v);
        if (v > 64'sd2147483647) begin
            sat_flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qdiv(longint a, longint b);
        return (a * (64'sd1 <<< FRACTION_BITS)) / b;
    endfunction

    function automatic void eliminate(int n);
        int     w;
        longint p;
        longint f;
        longint prow[2*MAX_SIZE];
        w = 2 * n;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                aug[r*w+n+c] = (r == c) ? (64'sd1 <<< FRACTION_BITS) : 0;
        for (int col = 0; col < n; col++) begin
            p = aug[col*w+col];
            if (p == 0) begin
                sing_flag = 1;
                continue;
            end
            for (int c = 0; c < w; c++) prow[c] = aug[col*w+c];
            for (int r = 0; r < n; r++) begin
                if (r == col) begin
                    for (int c = 0; c < w; c++) aug[r*w+c] = clip(qdiv(prow[c], p));
                end else begin
                    f = clip(qdiv(aug[r*w+col], p));
                    for (int c = 0; c < w; c++)
                        aug[r*w+c] = clip(aug[r*w+c] - (f * prow[c]) / (64'sd1 <<< FRACTION_BITS));
                end
            end
        end
    endfunction

    function automatic void load_element(logic signed [31:0] v);
        int        n;
        t_inv_beat b;
        n = (size_reg == 0) ? 1 : ((size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg));
        if (loaded >= n*n) loaded = 0;
        aug[(loaded/n)*2*n + loaded%n] = longint'(v);
        loaded++;
        if (loaded < n*n) return;
        eliminate(n);
        for (int k = 0; k < n*n; k++) begin
            b.elem = 32'(aug[(k/n)*2*n + n + k%n]);
            b.last = (k == n*n-1);
            b.sing = sing_flag;
            b.sat  = sat_flag;
            inverse_q.push_back(b);
        end
        loaded    = 0;
        sing_flag = 0;
        sat_flag  = 0;
    endfunction

    always @(posedge i_clk) begin
        t_inv_beat e;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            size_reg  <= 3'd4;
            loaded    = 0;
            sing_flag = 0;
            sat_flag  = 0;
            o_fail_count <= 0;
            inverse_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(4*REG_MATRIX_SIZE)) begin
                size_reg  <= pwdata[2:0];
                loaded    = 0;
                sing_flag = 0;
                sat_flag  = 0;
            end
            if (i_valid && o_ready) load_element(i_matrix_element);
            if (o_valid && i_ready) begin
                if (inverse_q.size() == 0) begin
                    $error("unexpected inverse beat %h", o_inverse_element);
                    errs++;
                end else begin
                    e = inverse_q.pop_front();
                    if (e.elem !== o_inverse_element) begin
                        $error("inverse_element exp %h got %h", e.elem, o_inverse_element);
                        errs++;
                    end
                    if (e.last !== o_last_element) begin
                        $error("last_element exp %b got %b", e.last, o_last_element);
                        errs++;
                    end
                    if (e.sing !== o_singular) begin
                        $error("singular exp %b got %b", e.sing, o_singular);
                        errs++;
                    end
                    if (e.sat !== o_saturated) begin
                        $error("saturated exp %b got %b", e.sat, o_saturated);
                        errs++;
                    end
                end
                o_fail_count <= o_fail_count + errs;
            end
        end
    end
endmodule

// File: bench/matrix_inverse_gauss_jordan_top_test.sv
// ----------------------------------------------------------------------------
// Gauss-Jordan inverter testbench
// Streams directed and random matrices at several sizes through the block,
// with bursty input, stalling output and size changes between phases.
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan_top_test;
    import migj_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 4000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [31:0] i_matrix_element = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic signed [31:0] o_inverse_element;
    logic               o_last_element;
    logic               o_singular;
    logic               o_saturated;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    bit                 long_hold = 0;
    int                 cur_size = 4;
    logic signed [31:0] directed_elems[$];

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    matrix_inverse_gauss_jordan_top u_dut (.*);

    matrix_inverse_gauss_jordan_checker u_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_ready, .i_matrix_element, .o_valid, .i_ready,
        .o_inverse_element, .o_last_element, .o_singular, .o_saturated,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else if (long_hold) i_ready <= 0;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[matrix_inverse_gauss_jordan_top] ERROR");
            $finish;
        end
    end

    task automatic write_size(logic [2:0] v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 3'(4*REG_MATRIX_SIZE); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cur_size = (v == 0) ? 1 : ((v > MAX_SIZE) ? MAX_SIZE : int'(v));
    endtask

    task automatic send_element(logic signed [31:0] v);
        i_valid <= 1;
        i_matrix_element <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_idle();
        i_valid <= 0;
        while (pending != 0 || o_valid) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    // bursty send of one matrix: mostly well-scaled values, some diagonal boost
    task automatic send_matrix(int kind);
        int burst;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < cur_size*cur_size; k++) begin
            if (burst == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 8);
            end
            if (kind == 2 && k / cur_size == k % cur_size)
                send_element(rand_elem(1) + 32'sh30000);
            else
                send_element(rand_elem(kind));
            burst--;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: identity, extremes, a singular case and saturation at size 2
        write_size(3'd2);
        directed_elems = {ONE_Q, 0, 0, ONE_Q,
                          32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                          0, ONE_Q, ONE_Q, 0,
                          1, 0, 0, 1,
                          -ONE_Q, 32'sh00020000, 32'sh00008000, 32'shffff0000};
        foreach (directed_elems[i]) send_element(directed_elems[i]);
        drain_idle();
        write_size(3'd1);
        send_element(0);
        send_element(32'sh80000000);
        send_element(1);
        drain_idle();
        write_size(3'd0);
        send_element(ONE_Q);
        // restart mid-load
        drain_idle();
        write_size(3'd3);
        send_element(ONE_Q);
        send_element(ONE_Q);
        drain_idle();
        write_size(3'd7);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain_idle();
                write_size(3'($urandom_range(1, 7)));
            end
            if (ph == 2) begin
                long_hold <= 1;
                fork
                    begin
                        repeat (4000) @(posedge i_clk);
                        long_hold <= 0;
                    end
                join_none
            end
            for (int m = 0; m < 3; m++) send_matrix($urandom_range(0, 2));
        end
        drain_idle();

        if (fail_count == 0) begin
            $display("[matrix_inverse_gauss_jordan_top] OK");
        end else begin
            $display("[matrix_inverse_gauss_jordan_top] ERROR");
        end
        $finish;
    end
endmodule
